@@ src/opg_pkg.sv @@
package opg_pkg;

  // field widths
  localparam int unsigned CTR_W     = 64;
  localparam int unsigned PST_W     = 8;
  localparam int unsigned UTIL_W    = 10;
  localparam int unsigned THR_W     = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  // per-core entry: {last_actual, last_reference, current_state}
  localparam int unsigned ENTRY_W = 2 * CTR_W + PST_W;

  // 100 * delta needs 71 bits
  localparam int unsigned PROD_W    = CTR_W + 7;
  localparam int unsigned DIV_CNT_W = 7;

  localparam logic [UTIL_W-1:0] UTIL_SAT = '1;

  // op codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_APPLY  = 2'd1;
  localparam logic [1:0] OP_PRIME  = 2'd2;

  // governors
  localparam logic [1:0] GOV_PERF     = 2'd0;
  localparam logic [1:0] GOV_SAVE     = 2'd1;
  localparam logic [1:0] GOV_ONDEMAND = 2'd2;

  // control modes
  localparam logic [1:0] MODE_LEGACY  = 2'd0;
  localparam logic [1:0] MODE_HWP     = 2'd1;
  localparam logic [1:0] MODE_INDEXED = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GOVERNOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PS_FLOOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PS_CEIL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UP_THR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_THR = 3'd6;

  // reset values
  localparam logic [PST_W-1:0] RST_PS_FLOOR = 8'd4;
  localparam logic [PST_W-1:0] RST_PS_CEIL  = 8'd20;
  localparam logic [PST_W-1:0] RST_BOOST    = 8'd20;
  localparam logic [THR_W-1:0] RST_UP_THR   = 7'd85;
  localparam logic [THR_W-1:0] RST_DOWN_THR = 7'd40;

  typedef enum logic [2:0] {
    KIND_BAD,
    KIND_PRIME,
    KIND_APPLY,
    KIND_SKIP,
    KIND_ZERO,
    KIND_SAMPLE
  } opg_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_LD,
    ST_CLS,
    ST_MULA,
    ST_MULB,
    ST_DGO,
    ST_DIV,
    ST_FIN
  } opg_state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic capture;
    logic mul_a;
    logic mul_b;
    logic div_start;
    logic finish;
  } opg_cmd_t;

  typedef struct packed {
    opg_kind_t kind;
    logic      div_done;
  } opg_stat_t;

endpackage

@@ src/opg_if.sv @@
interface opg_item_if;
  import opg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [5:0]           core;
  logic [CTR_W-1:0]     actual_cycles;
  logic [CTR_W-1:0]     reference_cycles;

  modport source (output valid, op, core, actual_cycles, reference_cycles, input ready);
  modport sink   (input valid, op, core, actual_cycles, reference_cycles, output ready);
endinterface

interface opg_result_if;
  import opg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 write_issued;
  logic [PST_W-1:0]     new_pstate;
  logic [PST_W-1:0]     request_min;
  logic [PST_W-1:0]     request_max;
  logic [UTIL_W-1:0]    util_percent;
  logic                 sample_skipped;

  modport source (output valid, write_issued, new_pstate, request_min, request_max,
                  util_percent, sample_skipped, input ready);
  modport sink   (input valid, write_issued, new_pstate, request_min, request_max,
                  util_percent, sample_skipped, output ready);
endinterface

interface opg_cfg_if;
  import opg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/opg_ram.sv @@
module opg_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/opg_div.sv @@
module opg_div
  import opg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [CTR_W-1:0]  divisor,
  output logic              done,
  output logic [UTIL_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    num;
  logic [CTR_W-1:0]     den;
  logic [CTR_W-1:0]     rem;
  logic [UTIL_W-1:0]    q;
  logic                 sat;

  logic [CTR_W:0]  rem_s;
  logic [CTR_W:0]  rem_d;
  logic            qbit;
  logic [UTIL_W:0] q_s;

  // restoring step: one quotient bit per cycle, quotient clamps at the 10-bit limit
  always_comb begin
    rem_s = {rem, num[PROD_W-1]};
    qbit  = (rem_s >= {1'b0, den});
    rem_d = qbit ? (rem_s - {1'b0, den}) : rem_s;
    q_s   = {q, qbit};
  end

  assign done = busy && (cnt == '0);
  assign quot = sat ? UTIL_SAT : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= DIV_CNT_W'(PROD_W - 1);
      num <= dividend;
      den <= divisor;
      rem <= '0;
      q   <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      num <= {num[PROD_W-2:0], 1'b0};
      rem <= rem_d[CTR_W-1:0];
      q   <= q_s[UTIL_W-1:0];
      if (q_s[UTIL_W]) begin
        sat <= 1'b1;
      end
    end
  end

endmodule

@@ src/opg_ctrl.sv @@
module opg_ctrl
  import opg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  output logic      result_valid,
  input  logic      result_ready,
  input  opg_stat_t stat,
  output opg_cmd_t  cmd
);

  opg_state_t state;
  opg_state_t state_next;
  logic       out_valid;
  logic       fin_ok;

  assign item_ready   = (state == ST_IDLE);
  assign result_valid = out_valid;
  assign fin_ok       = !out_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_LD;
      end
      ST_LD: begin
        cmd.capture = 1'b1;
        state_next  = ST_CLS;
      end
      ST_CLS: begin
        state_next = (stat.kind == KIND_SAMPLE) ? ST_MULA : ST_FIN;
      end
      ST_MULA: begin
        cmd.mul_a  = 1'b1;
        state_next = ST_MULB;
      end
      ST_MULB: begin
        cmd.mul_b  = 1'b1;
        state_next = ST_DGO;
      end
      ST_DGO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // result register must be free before the entry is written back
        if (fin_ok) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/opg_dp.sv @@
module opg_dp
  import opg_pkg::*;
#(
  parameter int unsigned NUM_CORES = 64,
  parameter int unsigned ADDR_W    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  // item payload
  input  logic [1:0]           op,
  input  logic [5:0]           core,
  input  logic [CTR_W-1:0]     actual_cycles,
  input  logic [CTR_W-1:0]     reference_cycles,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // result payload
  output logic                 write_issued,
  output logic [PST_W-1:0]     new_pstate,
  output logic [PST_W-1:0]     request_min,
  output logic [PST_W-1:0]     request_max,
  output logic [UTIL_W-1:0]    util_percent,
  output logic                 sample_skipped,
  input  opg_cmd_t             cmd,
  output opg_stat_t            stat
);

  // configuration registers
  logic [1:0]       governor;
  logic [1:0]       pstate_mode;
  logic [PST_W-1:0] ps_floor;
  logic [PST_W-1:0] ps_ceil;
  logic [PST_W-1:0] ps_boost;
  logic [THR_W-1:0] up_threshold;
  logic [THR_W-1:0] down_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      governor       <= GOV_PERF;
      pstate_mode    <= MODE_LEGACY;
      ps_floor       <= RST_PS_FLOOR;
      ps_ceil        <= RST_PS_CEIL;
      ps_boost       <= RST_BOOST;
      up_threshold   <= RST_UP_THR;
      down_threshold <= RST_DOWN_THR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOVERNOR: governor       <= cfg_data[1:0];
        REG_MODE:     pstate_mode    <= cfg_data[1:0];
        REG_PS_FLOOR: ps_floor       <= cfg_data;
        REG_PS_CEIL:  ps_ceil        <= cfg_data;
        REG_BOOST:    ps_boost       <= cfg_data;
        REG_UP_THR:   up_threshold   <= cfg_data[THR_W-1:0];
        REG_DOWN_THR: down_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]       op_r;
  logic [5:0]       core_r;
  logic [CTR_W-1:0] in_a;
  logic [CTR_W-1:0] in_m;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      core_r <= core;
      in_a   <= actual_cycles;
      in_m   <= reference_cycles;
    end
  end

  logic [8:0]        core_ext;
  logic [ADDR_W-1:0] idx;
  logic              core_bad;

  assign core_ext = {3'b000, core_r};
  assign idx      = core_ext[ADDR_W-1:0];
  assign core_bad = (core_ext >= 9'(NUM_CORES));

  // per-core store; an entry never written reads as zero through its valid bit
  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [NUM_CORES-1:0] valid;

  opg_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (NUM_CORES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[idx] <= 1'b1;
    end
  end

  logic [ENTRY_W-1:0] ent;
  logic [CTR_W-1:0]   ent_a;
  logic [CTR_W-1:0]   ent_m;
  logic [PST_W-1:0]   cur;
  logic [CTR_W-1:0]   da;
  logic [CTR_W-1:0]   dm;

  assign ent = valid[idx] ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ent_a <= ent[ENTRY_W-1 -: CTR_W];
      ent_m <= ent[PST_W +: CTR_W];
      cur   <= ent[PST_W-1:0];
      da    <= in_a - ent[ENTRY_W-1 -: CTR_W];
      dm    <= in_m - ent[PST_W +: CTR_W];
    end
  end

  logic div_done;

  // item classification
  always_comb begin
    stat.div_done = div_done;
    stat.kind     = KIND_BAD;
    if (!core_bad) begin
      case (op_r)
        OP_PRIME: stat.kind = KIND_PRIME;
        OP_APPLY: stat.kind = KIND_APPLY;
        OP_SAMPLE: begin
          if (governor != GOV_ONDEMAND) begin
            stat.kind = KIND_SKIP;
          end else if (dm == '0) begin
            stat.kind = KIND_ZERO;
          end else begin
            stat.kind = KIND_SAMPLE;
          end
        end
        default: stat.kind = KIND_BAD;
      endcase
    end
  end

  // 100 * da as (128 - 32) * da, then + 4 * da
  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      prod <= {da, 7'b0} - {2'b00, da, 5'b0};
    end else if (cmd.mul_b) begin
      prod <= prod + {5'b0, da, 2'b00};
    end
  end

  logic [UTIL_W-1:0] util;

  opg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (dm),
    .done     (div_done),
    .quot     (util)
  );

  // result and write-back
  logic              wr;
  logic              wb;
  logic              use_in;
  logic              skip;
  logic [PST_W-1:0]  tgt;
  logic [PST_W-1:0]  rmin_h;
  logic [PST_W-1:0]  rmax_h;
  logic [UTIL_W-1:0] util_o;
  logic [PST_W-1:0]  ps_o;
  logic              mode_hw;
  logic              mode_idx;
  logic [PST_W:0]    cur_up;
  logic [PST_W:0]    min_up;

  assign mode_hw  = (pstate_mode == MODE_HWP);
  assign mode_idx = (pstate_mode == MODE_INDEXED);
  assign cur_up   = {1'b0, cur} + 9'd1;
  assign min_up   = {1'b0, ps_floor} + 9'd1;

  always_comb begin
    wr     = 1'b0;
    wb     = 1'b0;
    use_in = 1'b0;
    skip   = 1'b0;
    tgt    = cur;
    rmin_h = ps_floor;
    rmax_h = ps_ceil;
    util_o = '0;
    case (stat.kind)
      KIND_PRIME: begin
        wb     = 1'b1;
        use_in = 1'b1;
      end
      KIND_APPLY: begin
        case (governor)
          GOV_PERF: begin
            wr = 1'b1;
            if (mode_hw) begin
              rmax_h = ps_boost;
              tgt    = ps_boost;
            end else if (mode_idx) begin
              tgt = ps_ceil;
            end else begin
              tgt = ps_boost;
            end
          end
          GOV_SAVE: begin
            wr     = 1'b1;
            rmax_h = ps_floor;
            tgt    = ps_floor;
          end
          default: ;
        endcase
        wb = wr;
      end
      KIND_ZERO: begin
        wb     = 1'b1;
        use_in = 1'b1;
        skip   = 1'b1;
      end
      KIND_SAMPLE: begin
        wb     = 1'b1;
        use_in = 1'b1;
        util_o = util;
        if (util > {3'b000, up_threshold}) begin
          if (mode_hw) begin
            tgt = ps_boost;
          end else begin
            tgt = (cur_up < {1'b0, ps_ceil}) ? cur_up[PST_W-1:0] : ps_ceil;
          end
        end else if (util < {3'b000, down_threshold}) begin
          tgt = ({1'b0, cur} > min_up) ? (cur - 8'd1) : ps_floor;
        end
        wr = (tgt != cur);
      end
      default: begin
        // bad item or sample outside ondemand
        skip = 1'b1;
      end
    endcase

    if (wr) begin
      ps_o = mode_idx ? {5'b00000, tgt[2:0]} : tgt;
    end else if (stat.kind == KIND_BAD) begin
      ps_o = '0;
    end else begin
      ps_o = cur;
    end
  end

  assign ram_we    = cmd.finish && wb;
  assign ram_wdata = use_in ? {in_a, in_m, (wr ? tgt : cur)} : {ent_a, ent_m, tgt};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      write_issued   <= wr;
      new_pstate     <= ps_o;
      request_min    <= (wr && mode_hw) ? rmin_h : '0;
      request_max    <= (wr && mode_hw) ? rmax_h : '0;
      util_percent   <= util_o;
      sample_skipped <= skip;
    end
  end

endmodule

@@ src/ondemand_pstate_governor.sv @@
// channel  dir  beat contents
// -------  ---  ---------------------------------------------------------------
// item     in   op, core, actual_cycles, reference_cycles
// result   out  write_issued, new_pstate, request_min, request_max,
//               util_percent, sample_skipped
// cfg      in   index (register number), data; always ready
//
// One item at a time. A sample under ondemand runs through the bit-serial divider
// (one quotient bit per cycle over the 71-bit product); other items skip the
// multiply and divide steps. item.ready returns with result.valid.
// rst is synchronous: registers to defaults, every core's entry reads as zero.
// A result waits in its own register; the next item is accepted meanwhile and
// stalls at its final step until the previous result has been taken.
module ondemand_pstate_governor
  import opg_pkg::*;
#(
  parameter int unsigned NUM_CORES = 64
) (
  input  logic          clk,
  input  logic          rst,
  opg_item_if.sink      item,
  opg_result_if.source  result,
  opg_cfg_if.sink       cfg
);

  localparam int unsigned ADDR_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  opg_cmd_t  cmd;
  opg_stat_t stat;

  assign cfg.ready = 1'b1;

  opg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  opg_dp #(
    .NUM_CORES (NUM_CORES),
    .ADDR_W    (ADDR_W)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .op               (item.op),
    .core             (item.core),
    .actual_cycles    (item.actual_cycles),
    .reference_cycles (item.reference_cycles),
    .cfg_we           (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .write_issued     (result.write_issued),
    .new_pstate       (result.new_pstate),
    .request_min      (result.request_min),
    .request_max      (result.request_max),
    .util_percent     (result.util_percent),
    .sample_skipped   (result.sample_skipped),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule
